FILE: rtl/core/matrix_factorization_sgd_step_assert.svh
// Assertion macros shared by the matrix factorization SGD step RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef MATRIX_FACTORIZATION_SGD_STEP_ASSERT_SVH
`define MATRIX_FACTORIZATION_SGD_STEP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define MFSGD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define MFSGD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/mfsgd_pkg.sv
// Shared constants, codes and types of the matrix factorization SGD step.
// Depends on nothing; imported by every module of the block.
package mfsgd_pkg;

	localparam int FEATURES = 25;
	localparam int USERS    = 4096;
	localparam int MOVIES   = 1024;

	localparam int ACTION_W   = 3;
	localparam int UIDX_W     = 12;
	localparam int MIDX_W     = 10;
	localparam int FIDX_W     = 5;
	localparam int DATA_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int U_DEPTH = USERS * FEATURES;
	localparam int M_DEPTH = MOVIES * FEATURES;
	localparam int UADDR_W = (U_DEPTH > 1) ? $clog2(U_DEPTH) : 1;
	localparam int MADDR_W = (M_DEPTH > 1) ? $clog2(M_DEPTH) : 1;
	localparam int FCNT_W  = (FEATURES > 1) ? $clog2(FEATURES) : 1;

	// Shared multiplier: a carries a gradient (up to 37 bits signed),
	// b carries a feature, the error or a zero-extended Q0.16 factor.
	localparam int MAC_A_W = 38;
	localparam int MAC_B_W = 18;
	localparam int ACC_W   = MAC_A_W + MAC_B_W;

	localparam int CLAMP_LOW       = 4096;
	localparam int CLAMP_HIGH      = 20480;
	localparam int DOT_FRAC        = 12;
	localparam int UPD_FRAC        = 32;
	localparam int FEAT_GAIN_SHIFT = 4;

	localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_REGULARIZATION = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_CLAMP_ENABLE   = CFG_IDX_W'(2);

	localparam logic [15:0] LRATE_RESET  = 16'd66;
	localparam logic [15:0] LAMBDA_RESET = 16'd1311;
	localparam logic        CLAMP_RESET  = 1'b1;

	typedef enum logic [ACTION_W-1:0] {
		ACT_WR_USER  = 3'd0,
		ACT_WR_MOVIE = 3'd1,
		ACT_TRAIN    = 3'd2,
		ACT_PREDICT  = 3'd3,
		ACT_RD_USER  = 3'd4,
		ACT_RD_MOVIE = 3'd5
	} action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADDR,
		ST_ACCESS,
		ST_FETCH,
		ST_DOT,
		ST_DRAIN,
		ST_PRED,
		ST_ERR,
		ST_UPD,
		ST_DONE
	} seq_state_t;

	typedef enum logic [1:0] {
		MAC_NOP,
		MAC_LOAD,
		MAC_ADD,
		MAC_SUB
	} mac_op_t;

	typedef struct packed {
		mac_op_t                     op;
		logic signed [MAC_A_W-1:0]   a;
		logic signed [MAC_B_W-1:0]   b;
	} mac_cmd_t;

	typedef struct packed {
		logic                u_we;
		logic                u_re;
		logic [UADDR_W-1:0]  u_addr;
		logic                m_we;
		logic                m_re;
		logic [MADDR_W-1:0]  m_addr;
		logic [DATA_W-1:0]   wdata;
	} store_req_t;

	typedef struct packed {
		logic [15:0] lrate;
		logic [15:0] lambda;
		logic        clamp;
	} cfg_t;

endpackage

FILE: rtl/core/mfsgd_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulator.
// Depends on mfsgd_pkg for operand widths and the command type.
module mfsgd_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mfsgd_pkg::mac_cmd_t                 cmd,
	output logic signed [mfsgd_pkg::ACC_W-1:0]  acc
);
	import mfsgd_pkg::*;

	logic signed [MAC_A_W-1:0] a;
	logic signed [MAC_B_W-1:0] b;
	logic signed [ACC_W-1:0]   prod_s1;
	mac_op_t                   op_s1;
	logic signed [ACC_W-1:0]   acc_q;

	assign a = cmd.a;
	assign b = cmd.b;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= MAC_NOP;
		end else begin
			op_s1 <= cmd.op;
		end
	end

	always_ff @(posedge clk) begin
		case (op_s1)
			MAC_LOAD: acc_q <= prod_s1;
			MAC_ADD:  acc_q <= acc_q + prod_s1;
			MAC_SUB:  acc_q <= acc_q - prod_s1;
			default:  acc_q <= acc_q;
		endcase
	end

	assign acc = acc_q;

endmodule

FILE: rtl/core/mfsgd_store.sv
// User and movie feature memories, one write and one registered read each.
// Depends on mfsgd_pkg for depths, address widths and the request type.
module mfsgd_store (
	input  logic                                  clk,
	input  mfsgd_pkg::store_req_t                 req,
	output logic signed [mfsgd_pkg::DATA_W-1:0]   u_rdata,
	output logic signed [mfsgd_pkg::DATA_W-1:0]   m_rdata
);
	import mfsgd_pkg::*;

	logic [DATA_W-1:0] umem [U_DEPTH];
	logic [DATA_W-1:0] mmem [M_DEPTH];
	logic [DATA_W-1:0] u_rdata_q;
	logic [DATA_W-1:0] m_rdata_q;

	always_ff @(posedge clk) begin
		if (req.u_we) begin
			umem[req.u_addr] <= req.wdata;
		end
		if (req.u_re) begin
			u_rdata_q <= umem[req.u_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.m_we) begin
			mmem[req.m_addr] <= req.wdata;
		end
		if (req.m_re) begin
			m_rdata_q <= mmem[req.m_addr];
		end
	end

	assign u_rdata = u_rdata_q;
	assign m_rdata = m_rdata_q;

endmodule

FILE: rtl/core/mfsgd_seq.sv
// Sequencer of the SGD step: item capture, feature walks, prediction,
// error, per-feature updates and the result register. Uses mfsgd_pkg.
module mfsgd_seq (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [mfsgd_pkg::ACTION_W-1:0]        action,
	input  logic [mfsgd_pkg::UIDX_W-1:0]          user_index,
	input  logic [mfsgd_pkg::MIDX_W-1:0]          movie_index,
	input  logic [mfsgd_pkg::FIDX_W-1:0]          feature_index,
	input  logic signed [mfsgd_pkg::DATA_W-1:0]   feature_value,
	input  logic signed [mfsgd_pkg::DATA_W-1:0]   rating,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [mfsgd_pkg::DATA_W-1:0]   prediction,
	output logic signed [mfsgd_pkg::DATA_W-1:0]   error,
	output logic signed [mfsgd_pkg::DATA_W-1:0]   read_value,
	input  mfsgd_pkg::cfg_t                       cfg,
	output mfsgd_pkg::store_req_t                 req,
	input  logic signed [mfsgd_pkg::DATA_W-1:0]   u_rdata,
	input  logic signed [mfsgd_pkg::DATA_W-1:0]   m_rdata,
	output mfsgd_pkg::mac_cmd_t                   mac_cmd,
	input  logic signed [mfsgd_pkg::ACC_W-1:0]    acc
);
	import mfsgd_pkg::*;

	// Schedule of one feature update (see the MAC pipeline: a command passes
	// through the product register, then lands in the accumulator register).
	localparam logic [3:0] UP_READ   = 4'd0;
	localparam logic [3:0] UP_ERR_M  = 4'd1;
	localparam logic [3:0] UP_REG_U  = 4'd2;
	localparam logic [3:0] UP_LR_U   = 4'd4;
	localparam logic [3:0] UP_ERR_U  = 4'd5;
	localparam logic [3:0] UP_WR_U   = 4'd6;
	localparam logic [3:0] UP_LR_M   = 4'd8;
	localparam logic [3:0] UP_WR_M   = 4'd10;
	localparam logic [3:0] DRAIN_END = 4'd1;

	localparam logic [FCNT_W-1:0] F_LAST = FCNT_W'(FEATURES - 1);

	seq_state_t                state_q, state_d;
	action_t                   act_q;
	logic [UIDX_W-1:0]         uid_q;
	logic [MIDX_W-1:0]         mid_q;
	logic [FIDX_W-1:0]         feat_q;
	logic signed [DATA_W-1:0]  fval_q;
	logic signed [DATA_W-1:0]  rating_q;
	logic                      uok_q, mok_q, fok_q;
	logic [UADDR_W-1:0]        ubase_q;
	logic [MADDR_W-1:0]        mbase_q;
	logic [FCNT_W-1:0]         f_q;
	logic [3:0]                step_q;
	logic                      rdv_q;
	logic                      first_q;
	logic signed [DATA_W-1:0]  pred_q, err_q, rdval_q;
	logic                      out_valid_q;
	logic signed [DATA_W-1:0]  prediction_q, error_q, read_value_q;
	logic                      done_load;
	logic signed [DATA_W-1:0]  upd_own;
	logic signed [DATA_W-1:0]  upd_value;
	logic signed [DATA_W-1:0]  dot_pred;
	logic signed [DATA_W-1:0]  err_value;

	// Round the Q6.24 dot product to Q3.12, clamp when enabled, saturate.
	function automatic logic signed [DATA_W-1:0] round_pred(
		input logic signed [ACC_W-1:0] s,
		input logic                    clamp
	);
		logic signed [ACC_W:0]          t;
		logic signed [ACC_W-DOT_FRAC:0] p;
		t = (ACC_W+1)'(s) + (ACC_W+1)'(1 << (DOT_FRAC - 1));
		p = t[ACC_W:DOT_FRAC];
		if (clamp && p < CLAMP_LOW) begin
			p = (ACC_W-DOT_FRAC+1)'(CLAMP_LOW);
		end else if (clamp && p > CLAMP_HIGH) begin
			p = (ACC_W-DOT_FRAC+1)'(CLAMP_HIGH);
		end
		if (p > 32767) begin
			p = (ACC_W-DOT_FRAC+1)'(32767);
		end else if (p < -32768) begin
			p = (ACC_W-DOT_FRAC+1)'(-32768);
		end
		return DATA_W'(p);
	endfunction

	// Add the rounded Q6.44 step to the old element and saturate.
	function automatic logic signed [DATA_W-1:0] apply_step(
		input logic signed [DATA_W-1:0] own,
		input logic signed [ACC_W-1:0]  d
	);
		logic signed [ACC_W:0]          t;
		logic signed [ACC_W-UPD_FRAC:0] r;
		logic signed [ACC_W-UPD_FRAC+1:0] s;
		t = (ACC_W+1)'(d) + ((ACC_W+1)'(1) << (UPD_FRAC - 1));
		r = t[ACC_W:UPD_FRAC];
		s = (ACC_W-UPD_FRAC+2)'(r) + (ACC_W-UPD_FRAC+2)'(own);
		if (s > 32767) begin
			s = (ACC_W-UPD_FRAC+2)'(32767);
		end else if (s < -32768) begin
			s = (ACC_W-UPD_FRAC+2)'(-32768);
		end
		return DATA_W'(s);
	endfunction

	// Rating minus prediction, saturated.
	function automatic logic signed [DATA_W-1:0] sub_sat(
		input logic signed [DATA_W-1:0] x,
		input logic signed [DATA_W-1:0] y
	);
		logic signed [DATA_W:0] s;
		s = (DATA_W+1)'(x) - (DATA_W+1)'(y);
		if (s > 32767) begin
			s = (DATA_W+1)'(32767);
		end else if (s < -32768) begin
			s = (DATA_W+1)'(-32768);
		end
		return DATA_W'(s);
	endfunction

	assign upd_own   = (step_q == UP_WR_U) ? u_rdata : m_rdata;
	assign upd_value = apply_step(upd_own, acc);
	assign dot_pred  = round_pred(acc, cfg.clamp);
	assign err_value = sub_sat(rating_q, pred_q);
	assign done_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		req = '0;
		req.wdata = fval_q;
		if (state_q == ST_ACCESS) begin
			req.u_addr = ubase_q + UADDR_W'(feat_q);
			req.m_addr = mbase_q + MADDR_W'(feat_q);
		end else begin
			req.u_addr = ubase_q + UADDR_W'(f_q);
			req.m_addr = mbase_q + MADDR_W'(f_q);
		end
		mac_cmd = '0;
		mac_cmd.op = MAC_NOP;
		// Dot product products are issued in the cycle after each streamed read.
		if (rdv_q) begin
			mac_cmd.op = first_q ? MAC_LOAD : MAC_ADD;
			mac_cmd.a = MAC_A_W'(u_rdata);
			mac_cmd.b = MAC_B_W'(m_rdata);
		end
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_ADDR;
				end
			end
			ST_ADDR: begin
				case (act_q)
					ACT_WR_USER, ACT_WR_MOVIE, ACT_RD_USER, ACT_RD_MOVIE: begin
						state_d = ST_ACCESS;
					end
					ACT_TRAIN, ACT_PREDICT: begin
						state_d = (uok_q && mok_q) ? ST_DOT : ST_DONE;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_ACCESS: begin
				state_d = ST_DONE;
				case (act_q)
					ACT_WR_USER:  req.u_we = uok_q && fok_q;
					ACT_WR_MOVIE: req.m_we = mok_q && fok_q;
					ACT_RD_USER: begin
						req.u_re = 1'b1;
						if (uok_q && fok_q) begin
							state_d = ST_FETCH;
						end
					end
					ACT_RD_MOVIE: begin
						req.m_re = 1'b1;
						if (mok_q && fok_q) begin
							state_d = ST_FETCH;
						end
					end
					default: ;
				endcase
			end
			ST_FETCH: state_d = ST_DONE;
			ST_DOT: begin
				req.u_re = 1'b1;
				req.m_re = 1'b1;
				if (f_q == F_LAST) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (step_q == DRAIN_END) begin
					state_d = ST_PRED;
				end
			end
			ST_PRED: state_d = (act_q == ACT_TRAIN) ? ST_ERR : ST_DONE;
			ST_ERR:  state_d = ST_UPD;
			ST_UPD: begin
				case (step_q)
					UP_READ: begin
						req.u_re = 1'b1;
						req.m_re = 1'b1;
					end
					UP_ERR_M: begin
						mac_cmd.op = MAC_LOAD;
						mac_cmd.a = MAC_A_W'(m_rdata) <<< FEAT_GAIN_SHIFT;
						mac_cmd.b = MAC_B_W'(err_q);
					end
					UP_REG_U: begin
						mac_cmd.op = MAC_SUB;
						mac_cmd.a = MAC_A_W'(u_rdata);
						mac_cmd.b = MAC_B_W'({1'b0, cfg.lambda});
					end
					UP_LR_U, UP_LR_M: begin
						mac_cmd.op = MAC_LOAD;
						mac_cmd.a = MAC_A_W'(acc);
						mac_cmd.b = MAC_B_W'({1'b0, cfg.lrate});
					end
					UP_ERR_U: begin
						mac_cmd.op = MAC_LOAD;
						mac_cmd.a = MAC_A_W'(u_rdata) <<< FEAT_GAIN_SHIFT;
						mac_cmd.b = MAC_B_W'(err_q);
					end
					UP_WR_U: begin
						req.u_we = 1'b1;
						req.wdata = upd_value;
						mac_cmd.op = MAC_SUB;
						mac_cmd.a = MAC_A_W'(m_rdata);
						mac_cmd.b = MAC_B_W'({1'b0, cfg.lambda});
					end
					UP_WR_M: begin
						req.m_we = 1'b1;
						req.wdata = upd_value;
						if (f_q == F_LAST) begin
							state_d = ST_DONE;
						end
					end
					default: ;
				endcase
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Counters and flags of the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_q <= '0;
			step_q <= '0;
			rdv_q <= 1'b0;
			first_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rdv_q <= (state_q == ST_DOT);
			if (rdv_q) begin
				first_q <= 1'b0;
			end
			case (state_q)
				ST_ADDR: begin
					f_q <= '0;
					step_q <= '0;
					first_q <= 1'b1;
				end
				ST_DOT: f_q <= (f_q == F_LAST) ? '0 : f_q + 1'b1;
				ST_DRAIN: step_q <= step_q + 1'b1;
				ST_ERR: begin
					f_q <= '0;
					step_q <= '0;
				end
				ST_UPD: begin
					if (step_q == UP_WR_M) begin
						step_q <= '0;
						f_q <= f_q + 1'b1;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				default: ;
			endcase
			if (done_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Captured item, address bases and working results.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			act_q <= action_t'(action);
			uid_q <= user_index;
			mid_q <= movie_index;
			feat_q <= feature_index;
			fval_q <= feature_value;
			rating_q <= rating;
			uok_q <= 32'(user_index) < USERS;
			mok_q <= 32'(movie_index) < MOVIES;
			fok_q <= 32'(feature_index) < FEATURES;
			pred_q <= '0;
			err_q <= '0;
			rdval_q <= '0;
		end
		if (state_q == ST_ADDR) begin
			ubase_q <= UADDR_W'(uid_q * FEATURES);
			mbase_q <= MADDR_W'(mid_q * FEATURES);
		end
		if (state_q == ST_FETCH) begin
			rdval_q <= (act_q == ACT_RD_USER) ? u_rdata : m_rdata;
		end
		if (state_q == ST_PRED) begin
			pred_q <= dot_pred;
		end
		if (state_q == ST_ERR) begin
			err_q <= err_value;
		end
		if (done_load) begin
			prediction_q <= pred_q;
			error_q <= err_q;
			read_value_q <= rdval_q;
		end
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign prediction = prediction_q;
	assign error      = error_q;
	assign read_value = read_value_q;

endmodule

FILE: rtl/core/matrix_factorization_sgd_step.sv
// Top level of the matrix factorization SGD step: configuration registers,
// sequencer, shared multiply-accumulate unit and the two feature memories.
`include "matrix_factorization_sgd_step_assert.svh"

// How to use this block.
// Input channel (in_valid / in_stall): one beat is one item. The action
// selects a single element write or read (user or movie), a prediction or
// a training step. The block takes one item at a time and holds in_stall
// high from the cycle after acceptance until its result beat is loaded.
// Output channel (out_valid / out_stall): exactly one beat per item, with
// prediction, error and read_value; fields that do not apply are zero.
// The single shared multiplier sets the work per item: one product per
// feature for the dot product, then six products per feature over an
// eleven-step schedule for the paired user and movie updates, each gated
// by the memory read port. A stalled result waits in the output register;
// the block then finishes the next item, if any, and holds it until the
// register frees up. Reset (arst_n low) empties the pipeline and restores
// the registers (learning rate 66, regularization 1311, clamping on).
// Feature memories are not cleared; elements must be written before they
// are read. The user must write configuration (cfg_write, cfg_index,
// cfg_data) only while idle; the block itself does not enforce this.
module matrix_factorization_sgd_step (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [mfsgd_pkg::ACTION_W-1:0]        action,
	input  logic [mfsgd_pkg::UIDX_W-1:0]          user_index,
	input  logic [mfsgd_pkg::MIDX_W-1:0]          movie_index,
	input  logic [mfsgd_pkg::FIDX_W-1:0]          feature_index,
	input  logic signed [mfsgd_pkg::DATA_W-1:0]   feature_value,
	input  logic signed [mfsgd_pkg::DATA_W-1:0]   rating,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [mfsgd_pkg::DATA_W-1:0]   prediction,
	output logic signed [mfsgd_pkg::DATA_W-1:0]   error,
	output logic signed [mfsgd_pkg::DATA_W-1:0]   read_value,
	input  logic                                  cfg_write,
	input  logic [mfsgd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mfsgd_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import mfsgd_pkg::*;

	cfg_t                     cfg_q;
	store_req_t               store_req;
	mac_cmd_t                 mac_cmd;
	logic signed [ACC_W-1:0]  acc;
	logic signed [DATA_W-1:0] u_rdata;
	logic signed [DATA_W-1:0] m_rdata;

	// Configuration registers; writes to an index beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lrate <= LRATE_RESET;
			cfg_q.lambda <= LAMBDA_RESET;
			cfg_q.clamp <= CLAMP_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_LEARNING_RATE:  cfg_q.lrate <= cfg_data[15:0];
				REG_REGULARIZATION: cfg_q.lambda <= cfg_data[15:0];
				REG_CLAMP_ENABLE:   cfg_q.clamp <= cfg_data[0];
				default: ;
			endcase
		end
	end

	mfsgd_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.user_index    (user_index),
		.movie_index   (movie_index),
		.feature_index (feature_index),
		.feature_value (feature_value),
		.rating        (rating),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.prediction    (prediction),
		.error         (error),
		.read_value    (read_value),
		.cfg           (cfg_q),
		.req           (store_req),
		.u_rdata       (u_rdata),
		.m_rdata       (m_rdata),
		.mac_cmd       (mac_cmd),
		.acc           (acc)
	);

	mfsgd_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.acc    (acc)
	);

	mfsgd_store u_store (
		.clk     (clk),
		.req     (store_req),
		.u_rdata (u_rdata),
		.m_rdata (m_rdata)
	);

	// An accepted beat makes the block busy in the very next cycle.
	`MFSGD_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "no stall after accepted beat")
	// Feature memories are only written while an item is being worked on.
	`MFSGD_ASSERT_IMPLIES(a_write_when_busy, clk, arst_n, store_req.u_we || store_req.m_we, in_stall, "memory write while idle")
	// A new result beat only comes out of an item that was being worked on.
	`MFSGD_ASSERT_IMPLIES(a_result_from_work, clk, arst_n, $rose(out_valid), $past(in_stall), "result without work")

endmodule
